// ===== src/gtfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gtfe_pkg;

  // input item packing on the slave side
  localparam int IN_DATA_W  = 264;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  // opcodes carried in the input tuser
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_LABEL = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic [4:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_LABEL,
    KIND_STEP,
    KIND_BAD
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_LREAD,
    B_LDONE,
    B_EMIT
  } bst_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [63:0] data;
    logic [63:0] mask;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  next_state;
    logic [2:0]  slot_used;
    logic [63:0] state_labels;
  } res_t;

endpackage

`default_nettype wire

// ===== src/gtfe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtfe_front #(
  parameter int MAX_STATES  = 16,
  parameter int INPUT_WIDTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [4:0]                     cfg_wdata,
  input  wire logic                           s_valid,
  output logic                                s_ready,
  input  wire logic [gtfe_pkg::IN_USER_W-1:0] s_user,
  input  wire logic [gtfe_pkg::IN_DATA_W-1:0] s_data,
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output gtfe_pkg::cmd_t                      push_entry
);

  localparam logic [63:0] ValMask = {64{1'b1}} >> (64 - INPUT_WIDTH);

  logic [4:0]  active;
  logic [3:0]  src;
  logic [3:0]  dst;
  logic [63:0] guard;
  logic [63:0] care;
  logic [63:0] labels;
  logic [63:0] inbits;
  logic        src_ok;
  logic        dst_ok;

  function automatic logic state_ok(input logic [3:0] s, input logic [4:0] act);
    state_ok = ({1'b0, s} < act) && (32'(s) < 32'(MAX_STATES));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= gtfe_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active <= cfg_wdata;
    end
  end

  assign src    = s_data[3:0];
  assign dst    = s_data[7:4];
  assign guard  = s_data[71:8];
  assign care   = s_data[135:72];
  assign labels = s_data[199:136];
  assign inbits = s_data[263:200];

  assign src_ok = state_ok(src, active);
  assign dst_ok = state_ok(dst, active);

  // classify and trim to the compared input width
  always_comb begin
    push_entry.src  = src;
    push_entry.dst  = dst;
    push_entry.mask = care & ValMask;
    push_entry.data = '0;
    push_entry.kind = gtfe_pkg::KIND_BAD;
    unique case (s_user)
      gtfe_pkg::OP_ADD: begin
        push_entry.data = guard & ValMask;
        push_entry.kind = (src_ok && dst_ok) ? gtfe_pkg::KIND_ADD : gtfe_pkg::KIND_BAD;
      end
      gtfe_pkg::OP_LABEL: begin
        push_entry.data = labels;
        push_entry.kind = src_ok ? gtfe_pkg::KIND_LABEL : gtfe_pkg::KIND_BAD;
      end
      gtfe_pkg::OP_STEP: begin
        push_entry.data = inbits & ValMask;
        push_entry.kind = src_ok ? gtfe_pkg::KIND_STEP : gtfe_pkg::KIND_BAD;
      end
      default: begin
        push_entry.kind = gtfe_pkg::KIND_BAD;
      end
    endcase
  end

  assign push_valid = s_valid;
  assign s_ready    = push_ready;

endmodule

`default_nettype wire

// ===== src/gtfe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtfe_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire gtfe_pkg::cmd_t push_entry,
  output logic                pop_valid,
  input  wire logic           pop,
  output gtfe_pkg::cmd_t      pop_entry
);

  localparam int Depth = 2;
  localparam int PW    = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  gtfe_pkg::cmd_t  entries [Depth];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== src/gtfe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtfe_back #(
  parameter int MAX_STATES      = 16,
  parameter int SLOTS_PER_STATE = 8,
  parameter int INPUT_WIDTH     = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire gtfe_pkg::cmd_t q_entry,
  output logic                q_pop,
  input  wire logic           out_ready,
  output logic                out_valid,
  output gtfe_pkg::res_t      out_res
);

  localparam int SW        = $clog2(MAX_STATES);
  localparam int KW        = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
  localparam int CW        = $clog2(SLOTS_PER_STATE + 1);
  localparam int SlotTotal = MAX_STATES * SLOTS_PER_STATE;
  localparam int AW        = $clog2(SlotTotal);

  gtfe_pkg::bst_t state;
  gtfe_pkg::bst_t state_next;

  // per-state fill counts and label valid bits
  logic [CW-1:0] filled [MAX_STATES];
  logic [MAX_STATES-1:0] label_vld;

  // slot and label stores
  logic [3:0]             slot_tgt [SlotTotal];
  logic [INPUT_WIDTH-1:0] slot_grd [SlotTotal];
  logic [INPUT_WIDTH-1:0] slot_msk [SlotTotal];
  logic [63:0]            label_mem [MAX_STATES];

  logic [3:0]             rd_tgt;
  logic [INPUT_WIDTH-1:0] rd_grd;
  logic [INPUT_WIDTH-1:0] rd_msk;
  logic [63:0]            lab_q;
  logic                   lab_ok;

  logic [SW-1:0]          head_sidx;
  logic [CW-1:0]          head_n;
  logic [AW-1:0]          head_base;
  logic                   head_room;

  logic [AW-1:0]          scan_base;
  logic [CW-1:0]          scan_n;
  logic [INPUT_WIDTH-1:0] scan_val;
  logic [CW-1:0]          issue_k;
  logic [KW-1:0]          chk_k;
  logic                   chk_vld;
  logic [AW-1:0]          scan_addr;
  logic                   rd_match;
  logic                   chk_last;
  logic [SW-1:0]          hit_tidx;
  logic                   hit_in_range;

  gtfe_pkg::res_t         res;
  gtfe_pkg::res_t         res_next;

  logic slot_we;
  logic lab_we;
  logic issue;
  logic lab_re;
  logic out_load;

  assign head_sidx = SW'(q_entry.src);
  assign head_n    = filled[head_sidx];
  assign head_base = AW'(head_sidx) * AW'(SLOTS_PER_STATE);
  assign head_room = head_n < CW'(SLOTS_PER_STATE);

  assign scan_addr    = scan_base + AW'(issue_k);
  assign rd_match     = ((scan_val ^ rd_grd) & rd_msk) == '0;
  assign chk_last     = CW'(chk_k) == (scan_n - CW'(1));
  assign hit_tidx     = SW'(res.next_state);
  assign hit_in_range = 32'(res.next_state) < 32'(MAX_STATES);

  always_comb begin
    state_next = state;
    unique case (state)
      gtfe_pkg::B_IDLE: begin
        if (q_valid) begin
          if (q_entry.kind == gtfe_pkg::KIND_STEP && head_n != '0) begin
            state_next = gtfe_pkg::B_SCAN;
          end else begin
            state_next = gtfe_pkg::B_EMIT;
          end
        end
      end
      gtfe_pkg::B_SCAN: begin
        if (chk_vld && rd_match) begin
          state_next = gtfe_pkg::B_LREAD;
        end else if (chk_vld && chk_last) begin
          state_next = gtfe_pkg::B_EMIT;
        end
      end
      gtfe_pkg::B_LREAD: state_next = gtfe_pkg::B_LDONE;
      gtfe_pkg::B_LDONE: state_next = gtfe_pkg::B_EMIT;
      gtfe_pkg::B_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = gtfe_pkg::B_IDLE;
        end
      end
      default: state_next = gtfe_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    slot_we  = 1'b0;
    lab_we   = 1'b0;
    issue    = 1'b0;
    lab_re   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      gtfe_pkg::B_IDLE: begin
        q_pop   = q_valid;
        slot_we = q_valid && q_entry.kind == gtfe_pkg::KIND_ADD && head_room;
        lab_we  = q_valid && q_entry.kind == gtfe_pkg::KIND_LABEL;
      end
      gtfe_pkg::B_SCAN:  issue    = issue_k < scan_n;
      gtfe_pkg::B_LREAD: lab_re   = 1'b1;
      gtfe_pkg::B_LDONE: ;
      gtfe_pkg::B_EMIT:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // result being built: initial value on pop, match data, then labels
  always_comb begin
    res_next = res;
    if (q_pop) begin
      res_next = '0;
      unique case (q_entry.kind)
        gtfe_pkg::KIND_ADD: begin
          if (head_room) begin
            res_next.status     = gtfe_pkg::ST_OK;
            res_next.next_state = q_entry.dst;
            res_next.slot_used  = 3'(head_n);
          end else begin
            res_next.status = gtfe_pkg::ST_FULL;
          end
        end
        gtfe_pkg::KIND_LABEL: res_next.status = gtfe_pkg::ST_OK;
        gtfe_pkg::KIND_STEP:  res_next.status = gtfe_pkg::ST_NOMATCH;
        default:              res_next.status = gtfe_pkg::ST_BAD;
      endcase
    end
    if (state == gtfe_pkg::B_SCAN && chk_vld && rd_match) begin
      res_next.status     = gtfe_pkg::ST_OK;
      res_next.next_state = rd_tgt;
      res_next.slot_used  = 3'(chk_k);
    end
    if (state == gtfe_pkg::B_LDONE) begin
      res_next.state_labels = lab_ok ? lab_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gtfe_pkg::B_IDLE;
      label_vld <= '0;
      chk_vld   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_STATES; i++) begin
        filled[i] <= '0;
      end
    end else begin
      state   <= state_next;
      chk_vld <= issue;
      if (slot_we) begin
        filled[head_sidx] <= head_n + CW'(1);
      end
      if (lab_we) begin
        label_vld[head_sidx] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_tgt[head_base + AW'(head_n)] <= q_entry.dst;
      slot_grd[head_base + AW'(head_n)] <= q_entry.data[INPUT_WIDTH-1:0];
      slot_msk[head_base + AW'(head_n)] <= q_entry.mask[INPUT_WIDTH-1:0];
    end
    if (issue) begin
      rd_tgt <= slot_tgt[scan_addr];
      rd_grd <= slot_grd[scan_addr];
      rd_msk <= slot_msk[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      label_mem[head_sidx] <= q_entry.data;
    end
    if (lab_re) begin
      lab_q <= label_mem[hit_tidx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      scan_base <= head_base;
      scan_n    <= head_n;
      scan_val  <= q_entry.data[INPUT_WIDTH-1:0];
      issue_k   <= '0;
    end
    if (issue) begin
      issue_k <= issue_k + CW'(1);
      chk_k   <= KW'(issue_k);
    end
    res <= res_next;
    if (lab_re) begin
      lab_ok <= label_vld[hit_tidx] && hit_in_range;
    end
    if (out_load) begin
      out_res <= res;
    end
  end

  // a checked slot always lies below the fill count of the scanned state
  a_chk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == gtfe_pkg::B_SCAN && chk_vld) |-> (CW'(chk_k) < scan_n))
    else $error("slot check beyond fill count");

  // fill counts never pass the slot list length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (head_n <= CW'(SLOTS_PER_STATE)))
    else $error("fill count overflow");

  // a new result only appears out of the emit state
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == gtfe_pkg::B_EMIT))
    else $error("result loaded outside emit");

  // the label fetch only follows a matching slot
  a_label_after_hit: assert property (@(posedge clk) disable iff (rst)
    (state == gtfe_pkg::B_LREAD) |-> (res.status == gtfe_pkg::ST_OK))
    else $error("label fetch without a match");

endmodule

`default_nettype wire

// ===== src/guarded_transition_fsm_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// programmable table-driven moore machine with masked guards
//
// slave stream: one transaction per command; tuser holds the opcode (add
// transition, set labels, step), tdata the state numbers and 64-bit fields.
// master stream: one transaction per command with status in tuser and
// next state, slot and labels in tdata.
// cfg_we/cfg_wdata write the number of active states; write only when idle.
//
// the front classifies each command (bad state numbers are caught here) and
// pushes it into a two-entry queue, so new commands are taken while the back
// works or while a result waits on the master side.
// add, label write, rejected command or step of an empty state go from the
// queue pop straight to the emit state; a step over the filled slots of its
// state (up to SLOTS_PER_STATE) makes one slot store read per cycle in add
// order until the first match, then, on a match, one label store read.
// the back works on one command at a time and pops the next only in idle.
// reset clears fill counts and label valid bits (labels read as zero) and
// sets the active state count to 16; no clearing pass is needed.
// a stalled master side holds the result; the back waits and the queue
// fills, after which s_axis_tready drops.
module guarded_transition_fsm_engine_top #(
  parameter int MAX_STATES      = 16,
  parameter int SLOTS_PER_STATE = 8,
  parameter int INPUT_WIDTH     = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [4:0]                      cfg_wdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // source_state, target_state, guard_bits, care_mask, label_bits, input_bits
  input  wire logic [gtfe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  wire logic [gtfe_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // next_state, slot_used, state_labels, one zero pad bit
  output logic [gtfe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // status
  output logic [gtfe_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

  logic           push_valid;
  logic           push_ready;
  gtfe_pkg::cmd_t push_entry;
  logic           q_valid;
  logic           q_pop;
  gtfe_pkg::cmd_t q_entry;
  gtfe_pkg::res_t out_res;

  // front: config register, command decode and state range checks
  gtfe_front #(
    .MAX_STATES  (MAX_STATES),
    .INPUT_WIDTH (INPUT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_user     (s_axis_tuser),
    .s_data     (s_axis_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // decoupling queue between decode and execution
  gtfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  // back: slot and label stores, guard scan and output register
  gtfe_back #(
    .MAX_STATES      (MAX_STATES),
    .SLOTS_PER_STATE (SLOTS_PER_STATE),
    .INPUT_WIDTH     (INPUT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res)
  );

  // pack the result, lowest field first
  assign m_axis_tdata = {1'b0, out_res.state_labels, out_res.slot_used, out_res.next_state};
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // opcode 3 is not used by the block and must be rejected
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STATE_TOTAL = 16;
  localparam int         NUM_SLOTS   = 8;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         MAX_REPORTS = 40;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  next_state;
    logic [2:0]  slot_used;
    logic [63:0] state_labels;
  } outcome_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [4:0]                      cfg_wdata = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [gtfe_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [gtfe_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [gtfe_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [gtfe_pkg::OUT_USER_W-1:0] m_axis_tuser;

  // shadow copy of the transition table, labels and active count
  logic [3:0]  tbl_target [STATE_TOTAL][NUM_SLOTS];
  logic [63:0] tbl_guard  [STATE_TOTAL][NUM_SLOTS];
  logic [63:0] tbl_mask   [STATE_TOTAL][NUM_SLOTS];
  logic [3:0]  tbl_fill   [STATE_TOTAL];
  logic [63:0] tbl_labels [STATE_TOTAL];
  logic [4:0]  active_count;

  outcome_t expected_q[$];

  int errors = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit idle_on = 1'b0;
  int sink_hold = 0;

  guarded_transition_fsm_engine_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cycle budget, generous against the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_q.size());
      $display("guarded_transition_fsm_engine_top test failed");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts while idle_on is set
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_hold <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic bit state_valid(logic [3:0] s);
    return ({1'b0, s} < active_count);
  endfunction

  // computes the result of one command and updates the shadow table
  function automatic outcome_t predict_outcome(logic [1:0] op, logic [3:0] src,
                                               logic [3:0] dst, logic [63:0] grd,
                                               logic [63:0] msk, logic [63:0] lab,
                                               logic [63:0] inp);
    outcome_t r;
    int n;
    logic [3:0] t;
    r.status = gtfe_pkg::ST_BAD;
    r.next_state = '0;
    r.slot_used = '0;
    r.state_labels = '0;
    case (op)
      gtfe_pkg::OP_ADD: begin
        if (state_valid(src) && state_valid(dst)) begin
          n = tbl_fill[src];
          if (n >= NUM_SLOTS) begin
            r.status = gtfe_pkg::ST_FULL;
          end else begin
            tbl_target[src][n] = dst;
            tbl_guard[src][n] = grd;
            tbl_mask[src][n] = msk;
            tbl_fill[src] = 4'(n + 1);
            r.status = gtfe_pkg::ST_OK;
            r.next_state = dst;
            r.slot_used = 3'(n);
          end
        end
      end
      gtfe_pkg::OP_LABEL: begin
        if (state_valid(src)) begin
          tbl_labels[src] = lab;
          r.status = gtfe_pkg::ST_OK;
        end
      end
      gtfe_pkg::OP_STEP: begin
        if (state_valid(src)) begin
          r.status = gtfe_pkg::ST_NOMATCH;
          // first slot in add order whose guard agrees on every cared bit
          for (int k = 0; k < tbl_fill[src]; k++) begin
            if (((inp ^ tbl_guard[src][k]) & tbl_mask[src][k]) == '0) begin
              t = tbl_target[src][k];
              r.status = gtfe_pkg::ST_OK;
              r.next_state = t;
              r.slot_used = 3'(k);
              r.state_labels = tbl_labels[t];
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one command transaction on the slave side, with an optional random gap
  task automatic send_cmd(logic [1:0] op, logic [3:0] src, logic [3:0] dst,
                          logic [63:0] grd, logic [63:0] msk, logic [63:0] lab,
                          logic [63:0] inp);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {inp, lab, msk, grd, dst, src};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_q.push_back(predict_outcome(op, src, dst, grd, msk, lab, inp));
    sent_count++;
    @(negedge clk);
  endtask

  // stop sending and wait until every result is back and the block is quiet
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // register write, only ever called after drain
  task automatic set_active(logic [4:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_count = value;
  endtask

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t mismatch %s: expected %h got %h", $time, name, exp, act);
    end
  endtask

  // result checker: each result transaction against the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none got status %h tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        status_seen[m_axis_tuser]++;
        check_field("status", 64'(want.status), 64'(m_axis_tuser));
        check_field("next_state", 64'(want.next_state), 64'(m_axis_tdata[3:0]));
        check_field("slot_used", 64'(want.slot_used), 64'(m_axis_tdata[6:4]));
        check_field("state_labels", want.state_labels, m_axis_tdata[70:7]);
      end
    end
  end

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_mask;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return rand64() & rand64() & rand64();
    endcase
  endfunction

  // mostly a state in use, sometimes any state number
  function automatic logic [3:0] pick_state;
    if ($urandom_range(0, 99) < 85)
      return 4'($urandom_range(0, active_count - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  // step inputs aimed at a filled slot, so later slots get matched too
  function automatic logic [63:0] step_input(logic [3:0] src);
    int k;
    if (tbl_fill[src] != 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, tbl_fill[src] - 1);
      return (tbl_guard[src][k] & tbl_mask[src][k]) | (rand64() & ~tbl_mask[src][k]);
    end
    return rand64();
  endfunction

  task automatic reset_model;
    foreach (tbl_fill[s]) begin
      tbl_fill[s] = '0;
      tbl_labels[s] = '0;
    end
    active_count = gtfe_pkg::ACTIVE_RESET;
  endtask

  // fresh table: nothing matches, label extremes
  task automatic test_empty_table;
    send_cmd(gtfe_pkg::OP_STEP, 4'd0, 4'd0, '0, '0, '0, '0);
    send_cmd(gtfe_pkg::OP_LABEL, 4'd15, 4'd0, '0, '0, '1, '0);
    send_cmd(gtfe_pkg::OP_LABEL, 4'd0, 4'd0, '0, '0, '0, '1);
    send_cmd(gtfe_pkg::OP_STEP, 4'd15, 4'd0, '0, '0, '0, '1);
  endtask

  // add order decides which guard wins; don't-care slot behind an exact one
  task automatic test_add_and_step;
    send_cmd(gtfe_pkg::OP_ADD, 4'd0, 4'd15, '1, '1, '0, '0);
    send_cmd(gtfe_pkg::OP_ADD, 4'd0, 4'd1, '0, '0, '1, '1);
    send_cmd(gtfe_pkg::OP_STEP, 4'd0, 4'd0, '0, '0, '0, '1);
    send_cmd(gtfe_pkg::OP_STEP, 4'd0, 4'd0, '1, '1, '1, 64'hffff_ffff_ffff_fffe);
  endtask

  // fill every slot of one state, then one add too many
  task automatic test_full_slots;
    for (int k = 0; k < NUM_SLOTS; k++)
      send_cmd(gtfe_pkg::OP_ADD, 4'd3, 4'(k + 8), 64'(k) << 60, 64'hf << 60, '0, '0);
    send_cmd(gtfe_pkg::OP_ADD, 4'd3, 4'd2, '0, '0, '0, '0);
    send_cmd(gtfe_pkg::OP_STEP, 4'd3, 4'd0, '0, '0, '0, 64'h7 << 60);
  endtask

  // state numbers beyond the active count, unused opcode, and a stored
  // target that falls outside the range once the count shrinks
  task automatic test_bad_states;
    drain();
    set_active(5'd4);
    send_cmd(gtfe_pkg::OP_ADD, 4'd5, 4'd0, '0, '0, '0, '0);
    send_cmd(gtfe_pkg::OP_ADD, 4'd1, 4'd4, '0, '0, '0, '0);
    send_cmd(gtfe_pkg::OP_LABEL, 4'd4, 4'd0, '0, '0, '1, '0);
    send_cmd(gtfe_pkg::OP_STEP, 4'd4, 4'd0, '0, '0, '0, '0);
    send_cmd(OP_UNUSED, 4'd1, 4'd2, '1, '1, '1, '1);
    send_cmd(gtfe_pkg::OP_ADD, 4'd1, 4'd3, '0, '0, '0, '0);
    drain();
    set_active(5'd2);
    send_cmd(gtfe_pkg::OP_STEP, 4'd1, 4'd0, '0, '0, '0, rand64());
    drain();
    set_active(5'd1);
    send_cmd(gtfe_pkg::OP_STEP, 4'd1, 4'd0, '0, '0, '0, '0);
    send_cmd(gtfe_pkg::OP_STEP, 4'd0, 4'd0, '0, '0, '0, '1);
  endtask

  // random traffic, mostly steps that reach deep into the slot lists
  task automatic test_random_traffic(int count);
    int pick;
    logic [3:0] src;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      src = pick_state();
      if (pick < 12)
        send_cmd(gtfe_pkg::OP_ADD, src, pick_state(), rand64(), rand_mask(), rand64(),
                 rand64());
      else if (pick < 22)
        send_cmd(gtfe_pkg::OP_LABEL, src, 4'($urandom), rand64(), rand64(), rand64(),
                 rand64());
      else if (pick < 93)
        send_cmd(gtfe_pkg::OP_STEP, src, 4'($urandom), rand64(), rand64(), rand64(),
                 step_input(src));
      else
        send_cmd(2'($urandom), 4'($urandom), 4'($urandom), rand64(), rand64(),
                 rand64(), rand64());
    end
  endtask

  initial begin
    reset_model();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_on = 1'b1;

    test_empty_table();
    test_add_and_step();
    test_full_slots();
    test_bad_states();

    drain();
    set_active(5'd16);
    test_random_traffic(360);
    drain();
    set_active(5'd1);
    test_random_traffic(200);
    drain();
    set_active(5'($urandom_range(2, 15)));
    test_random_traffic(400);
    drain();
    set_active(5'd8);
    test_random_traffic(400);
    drain();
    set_active(5'd16);
    idle_on = 1'b0;
    test_random_traffic(440);

    drain();
    $display("ran %0d commands over active counts 1 to 16 with stalls on both sides",
             sent_count);
    $display("results: ok %0d, no match %0d, slots full %0d, bad state %0d",
             status_seen[gtfe_pkg::ST_OK], status_seen[gtfe_pkg::ST_NOMATCH],
             status_seen[gtfe_pkg::ST_FULL], status_seen[gtfe_pkg::ST_BAD]);
    if (errors == 0)
      $display("guarded_transition_fsm_engine_top test passed");
    else
      $display("guarded_transition_fsm_engine_top test failed");
    $finish;
  end

endmodule
